>>> src/ucm_pkg.sv
// Shared constants and case mapping functions for the Unicode case mapper.
`timescale 1ns / 1ps

package ucm_pkg;

    localparam int CP_W = 21;

    typedef logic [CP_W-1:0] t_cp;

    // Direction codes carried on the cmd field
    localparam logic DIR_UPPER = 1'b0;
    localparam logic DIR_LOWER = 1'b1;

    localparam t_cp CP_Y_DIAER_UP = 21'h000178;
    localparam t_cp CP_LONG_S     = 21'h00017F;
    localparam t_cp CP_DOTTED_I   = 21'h000130;
    localparam t_cp CP_DOTLESS_I  = 21'h000131;
    localparam t_cp CP_Y_DIAER_LO = 21'h0000FF;
    localparam t_cp CP_LATB_LAST  = 21'h000217;
    localparam t_cp CP_CYR_LAST   = 21'h00047F;
    localparam t_cp CP_ARM_END    = 21'h000587;
    localparam t_cp CP_ARM_UP_END = 21'h000556;
    localparam t_cp CP_GEO_LAST   = 21'h0010C5;
    localparam t_cp CP_FW_LO_LAST = 21'h00FF5A;
    localparam t_cp CP_FW_UP_LAST = 21'h00FF3A;

    localparam t_cp CP_LATIN_CAP_I   = 21'h000049;
    localparam t_cp CP_LATIN_SMALL_I = 21'h000069;
    localparam t_cp CP_LATIN_CAP_S   = 21'h000053;

    // Odd code points of a pair hold the small letter, except in 139-148 and 179-17E, where the even one does
    function automatic t_cp map_upper(input t_cp c);
        t_cp r;
        begin
            r = c;
            if (c >= 21'h61 && c <= 21'h7A) begin
                r = c - t_cp'(32);
            end else if (c < 21'hE0) begin
                r = c;
            end else if (c <= 21'hF6 || (c >= 21'hF8 && c <= 21'hFE)) begin
                r = c - t_cp'(32);
            end else if (c == CP_Y_DIAER_LO) begin
                r = CP_Y_DIAER_UP;
            end else if ((c >= 21'h100 && c < 21'h138) ||
                         (c > 21'h149 && c < CP_Y_DIAER_UP)) begin
                if (c == CP_DOTTED_I || c == CP_DOTLESS_I) begin
                    r = CP_LATIN_CAP_I;
                end else begin
                    r = c[0] ? c - t_cp'(1) : c;
                end
            end else if ((c >= 21'h139 && c < 21'h149) ||
                         (c > CP_Y_DIAER_UP && c < CP_LONG_S)) begin
                r = c[0] ? c : c - t_cp'(1);
            end else if (c == CP_LONG_S) begin
                r = CP_LATIN_CAP_S;
            end else if (c >= 21'h200 && c <= CP_LATB_LAST) begin
                r = c[0] ? c - t_cp'(1) : c;
            end else if (c >= 21'h430 && c <= 21'h44F) begin
                r = c - t_cp'(32);
            end else if ((c >= 21'h451 && c <= 21'h45C) ||
                         (c >= 21'h45E && c <= 21'h45F)) begin
                r = c - t_cp'(80);
            end else if (c >= 21'h460 && c <= CP_CYR_LAST) begin
                r = c[0] ? c - t_cp'(1) : c;
            end else if (c >= 21'h561 && c < CP_ARM_END) begin
                r = c - t_cp'(48);
            end else if (c >= 21'hFF41 && c <= CP_FW_LO_LAST) begin
                r = c - t_cp'(32);
            end
            return r;
        end
    endfunction

    function automatic t_cp map_lower(input t_cp c);
        t_cp r;
        begin
            r = c;
            if (c >= 21'h41 && c <= 21'h5A) begin
                r = c + t_cp'(32);
            end else if (c < 21'hC0) begin
                r = c;
            end else if (c <= 21'hD6 || (c >= 21'hD8 && c <= 21'hDE)) begin
                r = c + t_cp'(32);
            end else if ((c >= 21'h100 && c < 21'h138) ||
                         (c > 21'h149 && c < CP_Y_DIAER_UP)) begin
                if (c == CP_DOTTED_I || c == CP_DOTLESS_I) begin
                    r = CP_LATIN_SMALL_I;
                end else begin
                    r = c[0] ? c : c + t_cp'(1);
                end
            end else if (c == CP_Y_DIAER_UP) begin
                r = CP_Y_DIAER_LO;
            end else if ((c >= 21'h139 && c < 21'h149) ||
                         (c > CP_Y_DIAER_UP && c < CP_LONG_S)) begin
                r = c[0] ? c + t_cp'(1) : c;
            end else if (c >= 21'h200 && c <= CP_LATB_LAST) begin
                r = c[0] ? c : c + t_cp'(1);
            end else if ((c >= 21'h401 && c <= 21'h40C) ||
                         (c >= 21'h40E && c <= 21'h40F)) begin
                r = c + t_cp'(80);
            end else if (c >= 21'h410 && c <= 21'h42F) begin
                r = c + t_cp'(32);
            end else if (c >= 21'h460 && c <= CP_CYR_LAST) begin
                r = c[0] ? c : c + t_cp'(1);
            end else if (c >= 21'h531 && c <= CP_ARM_UP_END) begin
                r = c + t_cp'(48);
            end else if (c >= 21'h10A0 && c <= CP_GEO_LAST) begin
                r = c + t_cp'(48);
            end else if (c >= 21'hFF21 && c <= CP_FW_UP_LAST) begin
                r = c + t_cp'(32);
            end
            return r;
        end
    endfunction

endpackage

>>> src/unicode_case_mapper.sv
// Top level: registered single-pass Unicode simple case mapper.
//
//  channel  | direction | handshake               | payload
//  ---------+-----------+-------------------------+----------------------
//  input    | in        | i_in_valid / o_in_stall | i_cmd, i_code_point
//  result   | out       | o_out_valid / i_out_stall | o_mapped_point
//
// One item a cycle while the result side is not stalled; a result passes
// through the input register, the mapping logic and the result register,
// from which it is offered on o_out_valid.
// Synchronous active-low reset clears both stage valids; no other state.
// A stalled result holds in the result register while the input register
// still takes one more item; stall reaches the input only when both are full.
`timescale 1ns / 1ps

module unicode_case_mapper (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic                i_cmd,
    input  ucm_pkg::t_cp        i_code_point,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output ucm_pkg::t_cp        o_mapped_point
);
    import ucm_pkg::*;

    logic r_s1_valid;
    logic r_s1_cmd;
    t_cp  r_s1_cp;
    logic r_out_valid;
    t_cp  r_out_point;

    logic s2_ready;
    logic s1_ready;
    t_cp  n_out_point;

    assign s2_ready = !r_out_valid || !i_out_stall;
    assign s1_ready = !r_s1_valid || s2_ready;

    assign o_in_stall     = !s1_ready;
    assign o_out_valid    = r_out_valid;
    assign o_mapped_point = r_out_point;

    always_comb begin
        unique case (r_s1_cmd)
            DIR_LOWER: n_out_point = map_lower(r_s1_cp);
            default:   n_out_point = map_upper(r_s1_cp);
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s1_ready) begin
                r_s1_valid <= i_in_valid;
            end
            if (s2_ready) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    // payload registers: load on advance, hold otherwise
    always_ff @(posedge i_clk) begin
        if (s1_ready && i_in_valid) begin
            r_s1_cmd <= i_cmd;
            r_s1_cp  <= i_code_point;
        end
        if (s2_ready && r_s1_valid) begin
            r_out_point <= n_out_point;
        end
    end

    a_advance_fills_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && s2_ready |=> r_out_valid)
        else $error("advanced item did not reach result register");

    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> r_s1_valid && r_out_valid && i_out_stall)
        else $error("input stalled with room in the pipeline");

    a_high_plane_passes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && s2_ready && r_s1_cp[CP_W-1:16] != '0
        |=> r_out_point == $past(r_s1_cp))
        else $error("code point above the BMP was altered");

    a_ascii_stays_ascii: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && s2_ready && r_s1_cp[CP_W-1:7] == '0
        |=> r_out_point[CP_W-1:7] == '0)
        else $error("ASCII code point mapped outside ASCII");

endmodule
